### rtl/sbb_pkg.sv
// Shared item types, field widths and codes of the separable box blur.
package sbb_pkg;

  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int RADIUS_W   = 4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              opcode;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } out_item_t;

endpackage

### rtl/sbb_queue.sv
// Two-entry command queue between the front and the back of the blur.
module sbb_queue #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  input  logic pop,
  output T     pop_data,
  output logic full,
  output logic empty
);

  T     mem_r [2];
  logic wr_ptr_r, wr_ptr_nxt;
  logic rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/sbb_front.sv
// Front end: accepts items, tracks frame positions and issues blur commands.
module sbb_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 15,
  parameter type cmd_t = logic
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    eff_h,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]    eff_r,
  input  logic                               in_valid,
  input  sbb_pkg::in_item_t                  in_item,
  output logic                               in_stall,
  input  logic                               full,
  output logic                               push,
  output cmd_t                               push_cmd
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int YHW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int WIN   = 2 * MAX_RADIUS + 2;
  localparam int WINW  = $clog2(WIN);
  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int RINGW = $clog2(RING);
  localparam int CNTW  = $clog2(2 * MAX_RADIUS + 2);
  localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [XW-1:0]    col_r, col_nxt;
  logic [YHW-1:0]   row_r, row_nxt;
  logic [WINW-1:0]  cwin_r, cwin_nxt;
  logic [RINGW-1:0] in_ring_r, in_ring_nxt;
  logic [NW-1:0]    pcount_r, pcount_nxt;
  logic [XW-1:0]    out_x_r, out_x_nxt;
  logic [YW-1:0]    out_y_r, out_y_nxt;
  logic [RINGW-1:0] out_ring_r, out_ring_nxt;

  logic             frame_done, is_pix, emit, last, take, row_end;
  logic [NW-1:0]    thr;
  logic [RW-1:0]    k;
  logic [YHW:0]     y_plus_r, h_lim, v_hi;
  logic [RINGW:0]   v_start;

  assign in_stall = full;

  always_comb begin
    frame_done = (row_r == eff_h);
    is_pix     = (in_item.opcode == sbb_pkg::OP_PIXEL) && !frame_done;
    thr        = NW'(eff_r) * NW'(eff_w) + NW'(eff_r);
    emit       = frame_done || (is_pix && (pcount_r >= thr));
    take       = in_valid && !full;
    push       = take && (is_pix || emit);
    row_end    = (WW'(col_r) == eff_w - WW'(1));
    last       = (WW'(out_x_r) == eff_w - WW'(1)) && (YHW'(out_y_r) == eff_h - YHW'(1));

    // Clipped column window of the vertical pass.
    k        = (YHW'(out_y_r) >= YHW'(eff_r)) ? eff_r : RW'(out_y_r);
    y_plus_r = (YHW+1)'(out_y_r) + (YHW+1)'(eff_r);
    h_lim    = (YHW+1)'(eff_h) - (YHW+1)'(1);
    v_hi     = (y_plus_r > h_lim) ? h_lim : y_plus_r;
    v_start  = ((RINGW+1)'(out_ring_r) >= (RINGW+1)'(k)) ?
               (RINGW+1)'(out_ring_r) - (RINGW+1)'(k) :
               (RINGW+1)'(out_ring_r) + (RINGW+1)'(RING) - (RINGW+1)'(k);

    push_cmd.is_pixel = is_pix;
    push_cmd.row_end  = row_end;
    push_cmd.pixel    = {in_item.red_in, in_item.green_in, in_item.blue_in};
    push_cmd.col      = col_r;
    push_cmd.cwin     = cwin_r;
    push_cmd.in_ring  = in_ring_r;
    push_cmd.emit     = emit;
    push_cmd.last     = last;
    push_cmd.out_x    = out_x_r;
    push_cmd.v_start  = RINGW'(v_start);
    push_cmd.v_cnt    = CNTW'(v_hi - (YHW+1)'(out_y_r) + (YHW+1)'(k) + (YHW+1)'(1));

    col_nxt      = col_r;
    row_nxt      = row_r;
    cwin_nxt     = cwin_r;
    in_ring_nxt  = in_ring_r;
    pcount_nxt   = pcount_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_ring_nxt = out_ring_r;

    if (push && is_pix) begin
      pcount_nxt = pcount_r + NW'(1);
      if (row_end) begin
        col_nxt     = '0;
        cwin_nxt    = '0;
        row_nxt     = row_r + YHW'(1);
        in_ring_nxt = (in_ring_r == RINGW'(RING - 1)) ? '0 : in_ring_r + RINGW'(1);
      end else begin
        col_nxt  = col_r + XW'(1);
        cwin_nxt = (cwin_r == WINW'(WIN - 1)) ? '0 : cwin_r + WINW'(1);
      end
    end

    if (push && emit) begin
      if (WW'(out_x_r) == eff_w - WW'(1)) begin
        out_x_nxt    = '0;
        out_y_nxt    = out_y_r + YW'(1);
        out_ring_nxt = (out_ring_r == RINGW'(RING - 1)) ? '0 : out_ring_r + RINGW'(1);
      end else begin
        out_x_nxt = out_x_r + XW'(1);
      end
    end

    if (restart || (push && emit && last)) begin
      col_nxt      = '0;
      row_nxt      = '0;
      cwin_nxt     = '0;
      in_ring_nxt  = '0;
      pcount_nxt   = '0;
      out_x_nxt    = '0;
      out_y_nxt    = '0;
      out_ring_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      cwin_r     <= '0;
      in_ring_r  <= '0;
      pcount_r   <= '0;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_ring_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      cwin_r     <= cwin_nxt;
      in_ring_r  <= in_ring_nxt;
      pcount_r   <= pcount_nxt;
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_ring_r <= out_ring_nxt;
    end
  end

endmodule

### rtl/sbb_back.sv
// Back end: row window, row store, shared accumulate and divide, result register.
module sbb_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 15,
  parameter type cmd_t = logic
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(MAX_RADIUS+1)-1:0] eff_r,
  input  logic                            q_empty,
  input  cmd_t                            q_cmd,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sbb_pkg::out_item_t              out_item
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int PW    = ((XW > RW) ? XW : RW) + 1;
  localparam int WIN   = 2 * MAX_RADIUS + 2;
  localparam int WINW  = $clog2(WIN);
  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int RINGW = $clog2(RING);
  localparam int CNTW  = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUMW  = sbb_pkg::CHAN_W + CNTW;
  localparam int IW    = $clog2(SUMW);
  localparam int AW    = $clog2(RING * MAX_WIDTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_HSETUP = 7'b0000010,
    S_VSETUP = 7'b0000100,
    S_READ   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [XW-1:0]    hx_r, hx_nxt, hx_end_r, hx_end_nxt;
  logic             vert_r, vert_nxt;
  logic [WINW-1:0]  wptr_r, wptr_nxt;
  logic [RINGW-1:0] rptr_r, rptr_nxt;
  logic [CNTW-1:0]  left_r, left_nxt, cnt_r, cnt_nxt;
  logic             rvalid_r, rvalid_nxt;
  logic [SUMW-1:0]  acc_r [3];
  logic [SUMW-1:0]  acc_nxt [3];
  logic [SUMW-1:0]  num_r [3];
  logic [SUMW-1:0]  num_nxt [3];
  logic [CNTW-1:0]  rem_r [3];
  logic [CNTW-1:0]  rem_nxt [3];
  logic [7:0]       quo_r [3];
  logic [7:0]       quo_nxt [3];
  logic [IW-1:0]    div_i_r, div_i_nxt;
  logic             out_valid_r, out_valid_nxt;
  sbb_pkg::out_item_t out_item_r, out_item_nxt;

  sbb_pkg::rgb_t    win_mem [WIN];
  sbb_pkg::rgb_t    store_mem [RING * MAX_WIDTH];
  sbb_pkg::rgb_t    win_q_r, store_q_r, rd_data, quo_pix;

  logic             win_we, win_re, store_we, store_re, issue, has_h;
  logic [AW-1:0]    store_waddr, store_raddr;
  logic [XW-1:0]    lo_h, hi_h, first_hx;
  logic [CNTW-1:0]  h_cnt, h_dist;
  logic [WINW:0]    h_start;
  logic [CNTW:0]    shifted [3];

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    q_pop    = (state_r == S_IDLE) && !q_empty;
    has_h    = q_cmd.is_pixel && (q_cmd.row_end || (PW'(q_cmd.col) >= PW'(eff_r)));
    first_hx = (PW'(q_cmd.col) >= PW'(eff_r)) ? XW'(PW'(q_cmd.col) - PW'(eff_r)) : '0;

    // Clipped row window of the horizontal pass for column hx_r.
    lo_h    = (PW'(hx_r) >= PW'(eff_r)) ? XW'(PW'(hx_r) - PW'(eff_r)) : '0;
    hi_h    = ((PW'(hx_r) + PW'(eff_r)) > PW'(cmd_r.col)) ? cmd_r.col :
              XW'(PW'(hx_r) + PW'(eff_r));
    h_cnt   = CNTW'(PW'(hi_h) - PW'(lo_h) + PW'(1));
    h_dist  = CNTW'(PW'(cmd_r.col) - PW'(lo_h));
    h_start = ((WINW+1)'(cmd_r.cwin) >= (WINW+1)'(h_dist)) ?
              (WINW+1)'(cmd_r.cwin) - (WINW+1)'(h_dist) :
              (WINW+1)'(cmd_r.cwin) + (WINW+1)'(WIN) - (WINW+1)'(h_dist);

    issue    = (state_r == S_READ) && (left_r != '0);
    win_re   = issue && !vert_r;
    store_re = issue && vert_r;
    win_we   = q_pop && q_cmd.is_pixel;
    store_we = (state_r == S_FIN) && !vert_r;
    store_waddr = AW'(cmd_r.in_ring) * AW'(MAX_WIDTH) + AW'(hx_r);
    store_raddr = AW'(rptr_r) * AW'(MAX_WIDTH) + AW'(cmd_r.out_x);
    rd_data  = vert_r ? store_q_r : win_q_r;
    quo_pix  = {quo_r[0], quo_r[1], quo_r[2]};

    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    hx_nxt        = hx_r;
    hx_end_nxt    = hx_end_r;
    vert_nxt      = vert_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    left_nxt      = left_r;
    cnt_nxt       = cnt_r;
    rvalid_nxt    = 1'b0;
    div_i_nxt     = div_i_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = acc_r[c];
      num_nxt[c] = num_r[c];
      rem_nxt[c] = rem_r[c];
      quo_nxt[c] = quo_r[c];
      shifted[c] = {rem_r[c], num_r[c][SUMW-1]};
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cmd_nxt    = q_cmd;
          hx_nxt     = first_hx;
          hx_end_nxt = q_cmd.row_end ? q_cmd.col : first_hx;
          if (has_h) begin
            state_nxt = S_HSETUP;
          end else if (q_cmd.emit) begin
            state_nxt = S_VSETUP;
          end
        end
      end
      S_HSETUP: begin
        wptr_nxt  = WINW'(h_start);
        left_nxt  = h_cnt;
        cnt_nxt   = h_cnt;
        vert_nxt  = 1'b0;
        for (int c = 0; c < 3; c++) acc_nxt[c] = '0;
        state_nxt = S_READ;
      end
      S_VSETUP: begin
        rptr_nxt  = cmd_r.v_start;
        left_nxt  = cmd_r.v_cnt;
        cnt_nxt   = cmd_r.v_cnt;
        vert_nxt  = 1'b1;
        for (int c = 0; c < 3; c++) acc_nxt[c] = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (issue) begin
          left_nxt   = left_r - CNTW'(1);
          rvalid_nxt = 1'b1;
          wptr_nxt   = (wptr_r == WINW'(WIN - 1)) ? '0 : wptr_r + WINW'(1);
          rptr_nxt   = (rptr_r == RINGW'(RING - 1)) ? '0 : rptr_r + RINGW'(1);
        end
        if (rvalid_r) begin
          acc_nxt[0] = acc_r[0] + SUMW'(rd_data.red);
          acc_nxt[1] = acc_r[1] + SUMW'(rd_data.green);
          acc_nxt[2] = acc_r[2] + SUMW'(rd_data.blue);
        end else if (!issue) begin
          for (int c = 0; c < 3; c++) begin
            num_nxt[c] = acc_r[c];
            rem_nxt[c] = '0;
            quo_nxt[c] = '0;
          end
          div_i_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // One restoring division step per channel each cycle.
        for (int c = 0; c < 3; c++) begin
          num_nxt[c] = num_r[c] << 1;
          if (shifted[c] >= {1'b0, cnt_r}) begin
            rem_nxt[c] = CNTW'(shifted[c] - {1'b0, cnt_r});
            quo_nxt[c] = {quo_r[c][6:0], 1'b1};
          end else begin
            rem_nxt[c] = CNTW'(shifted[c]);
            quo_nxt[c] = {quo_r[c][6:0], 1'b0};
          end
        end
        div_i_nxt = div_i_r + IW'(1);
        if (div_i_r == IW'(SUMW - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (vert_r) begin
          state_nxt = S_OUT;
        end else if (hx_r != hx_end_r) begin
          hx_nxt    = hx_r + XW'(1);
          state_nxt = S_HSETUP;
        end else begin
          state_nxt = cmd_r.emit ? S_VSETUP : S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.red_out   = quo_pix.red;
          out_item_nxt.green_out = quo_pix.green;
          out_item_nxt.blue_out  = quo_pix.blue;
          out_item_nxt.frame_end = cmd_r.last;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    hx_r       <= hx_nxt;
    hx_end_r   <= hx_end_nxt;
    vert_r     <= vert_nxt;
    wptr_r     <= wptr_nxt;
    rptr_r     <= rptr_nxt;
    left_r     <= left_nxt;
    cnt_r      <= cnt_nxt;
    div_i_r    <= div_i_nxt;
    out_item_r <= out_item_nxt;
    for (int c = 0; c < 3; c++) begin
      acc_r[c] <= acc_nxt[c];
      num_r[c] <= num_nxt[c];
      rem_r[c] <= rem_nxt[c];
      quo_r[c] <= quo_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[q_cmd.cwin] <= q_cmd.pixel;
    end
    if (win_re) begin
      win_q_r <= win_mem[wptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= quo_pix;
    end
    if (store_re) begin
      store_q_r <= store_mem[store_raddr];
    end
  end

endmodule

### rtl/separable_box_blur_rgb_unit.sv
// Top level of the separable box blur: configuration registers, front, queue and back.
//
// Usage. RGB pixels enter in raster order on the in_ channel, one item each; an
// item is taken at a clock edge where in_valid is high and in_stall is low.
// Opcode pixel carries a pixel, opcode drain carries none and flushes the tail
// of a frame once every pixel of the frame has arrived. Blurred pixels leave on
// the out_ channel in raster order, R rows plus R pixels behind the input, with
// frame_end set on the last one of the frame.
// Registers image_width, image_height and blur_radius are written through the
// cfg_ port (always ready); the user writes them only while the block is idle;
// nothing in the block enforces this. A write to one of them restarts the frame.
// One item is worked at a time by the back end. Each horizontal or vertical
// average reads its clipped window of cnt entries (at most 2R+1) from the window
// or row store, one entry per cycle, then runs the shared bit-serial divider for
// SUMW = 8 + clog2(2*MAX_RADIUS+2) steps. A pixel item costs at most one
// horizontal average (up to R+1 at a row end), plus a vertical one for a result.
// Reset is synchronous and active low; it restores the register defaults and
// empties the queue and the result register. The row store needs no clearing.
// When the receiver stalls, the result register holds its item; the front keeps
// taking items until its two-entry queue is full, then raises in_stall.
module separable_box_blur_rgb_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sbb_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sbb_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int YHW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int WINW  = $clog2(2 * MAX_RADIUS + 2);
  localparam int RINGW = $clog2(2 * MAX_RADIUS + 1);
  localparam int CNTW  = $clog2(2 * MAX_RADIUS + 2);

  // One unit of work for the back end, produced per pushed item.
  typedef struct packed {
    logic             is_pixel;
    logic             row_end;
    sbb_pkg::rgb_t    pixel;
    logic [XW-1:0]    col;
    logic [WINW-1:0]  cwin;
    logic [RINGW-1:0] in_ring;
    logic             emit;
    logic             last;
    logic [XW-1:0]    out_x;
    logic [RINGW-1:0] v_start;
    logic [CNTW-1:0]  v_cnt;
  } cmd_t;

  logic [sbb_pkg::WIDTH_W-1:0]  width_r, width_nxt;
  logic [sbb_pkg::HEIGHT_W-1:0] height_r, height_nxt;
  logic [sbb_pkg::RADIUS_W-1:0] radius_r, radius_nxt;
  logic [WW-1:0]  eff_w;
  logic [YHW-1:0] eff_h;
  logic [RW-1:0]  eff_r;
  logic           cfg_we, restart;
  logic           q_push, q_pop, q_full, q_empty;
  cmd_t           push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    radius_nxt = radius_r;
    restart    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        sbb_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = cfg_wdata[sbb_pkg::WIDTH_W-1:0];
          restart   = 1'b1;
        end
        sbb_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_wdata[sbb_pkg::HEIGHT_W-1:0];
          restart    = 1'b1;
        end
        sbb_pkg::REG_BLUR_RADIUS: begin
          radius_nxt = cfg_wdata[sbb_pkg::RADIUS_W-1:0];
          restart    = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end

    // Out-of-range settings are clamped to what the storage supports.
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = YHW'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      eff_h = YHW'(MAX_HEIGHT);
    end else begin
      eff_h = YHW'(height_r);
    end
    eff_r = (int'(radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sbb_pkg::WIDTH_RESET;
      height_r <= sbb_pkg::HEIGHT_RESET;
      radius_r <= sbb_pkg::RADIUS_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      radius_r <= radius_nxt;
    end
  end

  sbb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS),
    .cmd_t     (cmd_t)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .eff_r   (eff_r),
    .in_valid(in_valid),
    .in_item (in_item),
    .in_stall(in_stall),
    .full    (q_full),
    .push    (q_push),
    .push_cmd(push_cmd)
  );

  sbb_queue #(
    .T(cmd_t)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_cmd),
    .pop      (q_pop),
    .pop_data (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  sbb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS),
    .cmd_t     (cmd_t)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_r    (eff_r),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

### rtl/sbb_checker.sv
// Port-level checks of the box blur, bound to the top level.
module sbb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sbb_pkg::out_item_t out_item
);

  // A result held by the receiver stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or vanished while stalled");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the command queue, so input is open right away.
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind separable_box_blur_rgb_unit sbb_checker u_sbb_checker (.*);

### dv/separable_box_blur_rgb_unit_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the blurred pixel stream and compares it with the block.
module separable_box_blur_rgb_unit_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  sbb_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  sbb_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending
);

  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 2;
  localparam int RING_ROWS = 2 * MAX_RADIUS + 1;

  int unsigned        width_reg, height_reg, radius_reg;
  sbb_pkg::rgb_t      pixel_window [WIN_DEPTH];
  sbb_pkg::rgb_t      blurred_rows [RING_ROWS * MAX_WIDTH];
  int unsigned        next_col, next_row, next_out;
  sbb_pkg::out_item_t blurred_q [$];

  assign pending = blurred_q.size();

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Horizontal average of column x of the current row, kept for row y.
  task automatic blur_row_pixel(int unsigned x, int unsigned y, int unsigned w,
                                int unsigned r);
    int unsigned lo, hi, cnt, sr, sg, sb;
    sbb_pkg::rgb_t px, res;
    lo = (x >= r) ? x - r : 0;
    hi = (x + r > w - 1) ? w - 1 : x + r;
    cnt = hi - lo + 1;
    sr = 0; sg = 0; sb = 0;
    for (int unsigned i = lo; i <= hi; i++) begin
      px = pixel_window[i % WIN_DEPTH];
      sr += px.red; sg += px.green; sb += px.blue;
    end
    res.red = 8'(sr / cnt);
    res.green = 8'(sg / cnt);
    res.blue = 8'(sb / cnt);
    blurred_rows[(y % RING_ROWS) * MAX_WIDTH + (x % MAX_WIDTH)] = res;
  endtask

  // Vertical average for the next output position.
  task automatic emit_blurred(int unsigned w, int unsigned h, int unsigned r);
    int unsigned p, x, y, lo, hi, cnt, sr, sg, sb;
    sbb_pkg::rgb_t px;
    sbb_pkg::out_item_t res;
    p = next_out;
    x = p % w;
    y = p / w;
    lo = (y >= r) ? y - r : 0;
    hi = (y + r > h - 1) ? h - 1 : y + r;
    cnt = hi - lo + 1;
    sr = 0; sg = 0; sb = 0;
    for (int unsigned i = lo; i <= hi; i++) begin
      px = blurred_rows[(i % RING_ROWS) * MAX_WIDTH + (x % MAX_WIDTH)];
      sr += px.red; sg += px.green; sb += px.blue;
    end
    res.red_out = 8'(sr / cnt);
    res.green_out = 8'(sg / cnt);
    res.blue_out = 8'(sb / cnt);
    res.frame_end = (p == w * h - 1);
    blurred_q.push_back(res);
    if (res.frame_end) begin
      next_col = 0; next_row = 0; next_out = 0;
    end else begin
      next_out = p + 1;
    end
  endtask

  task automatic take_item(sbb_pkg::in_item_t it);
    int unsigned w, h, r, c, n;
    sbb_pkg::rgb_t px;
    w = clip(width_reg, 1, MAX_WIDTH);
    h = clip(height_reg, 1, MAX_HEIGHT);
    r = clip(radius_reg, 0, MAX_RADIUS);
    if (it.opcode == sbb_pkg::OP_DRAIN || next_row >= h) begin
      if (next_row >= h) emit_blurred(w, h, r);
      return;
    end
    c = next_col;
    px.red = it.red_in; px.green = it.green_in; px.blue = it.blue_in;
    pixel_window[c % WIN_DEPTH] = px;
    if (c == w - 1) begin
      for (int unsigned x = (c >= r) ? c - r : 0; x < w; x++)
        blur_row_pixel(x, next_row, w, r);
    end else if (c >= r) begin
      blur_row_pixel(c - r, next_row, w, r);
    end
    n = next_row * w + c;
    if (c + 1 >= w) begin
      next_col = 0;
      next_row++;
    end else begin
      next_col = c + 1;
    end
    if (n >= r * w + r) emit_blurred(w, h, r);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors = 0;
      foreach (pixel_window[i]) pixel_window[i] = '0;
      width_reg = sbb_pkg::WIDTH_RESET;
      height_reg = sbb_pkg::HEIGHT_RESET;
      radius_reg = sbb_pkg::RADIUS_RESET;
      next_col = 0; next_row = 0; next_out = 0;
      blurred_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sbb_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_wdata[sbb_pkg::WIDTH_W-1:0];
          sbb_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_wdata[sbb_pkg::HEIGHT_W-1:0];
          sbb_pkg::REG_BLUR_RADIUS:  radius_reg = cfg_wdata[sbb_pkg::RADIUS_W-1:0];
          default: ;
        endcase
        if (cfg_index inside {sbb_pkg::REG_IMAGE_WIDTH, sbb_pkg::REG_IMAGE_HEIGHT,
                              sbb_pkg::REG_BLUR_RADIUS}) begin
          next_col = 0; next_row = 0; next_out = 0;
        end
      end
      if (in_valid && !in_stall) take_item(in_item);
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          $error("unexpected output item");
          errors++;
        end else begin
          sbb_pkg::out_item_t e;
          e = blurred_q.pop_front();
          check_field("red_out", e.red_out, out_item.red_out);
          check_field("green_out", e.green_out, out_item.green_out);
          check_field("blue_out", e.blue_out, out_item.blue_out);
          check_field("frame_end", e.frame_end, out_item.frame_end);
        end
      end
    end
  end

endmodule

### dv/separable_box_blur_rgb_unit_tb.sv
`timescale 1ns / 1ps
// Top of the separable box blur testbench: clock, reset, stimulus and verdict.
module separable_box_blur_rgb_unit_tb;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [sbb_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 2500;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int TOTAL_ITEMS = 1500;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  sbb_pkg::in_item_t              in_item;
  logic                           out_valid;
  logic                           out_stall;
  sbb_pkg::out_item_t             out_item;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             errors;
  int                             pending;

  // Shadow of the registers, used only to size frames and their drain tails.
  int unsigned cur_width, cur_height, cur_radius;
  int          items_sent;
  int          stall_hold;
  longint      cycles = 0;

  separable_box_blur_rgb_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  separable_box_blur_rgb_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A hard ceiling on the run, far above the slowest legal schedule.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL separable_box_blur_rgb_unit");
      $finish;
    end
  end

  // The receiver stalls in runs: mostly open stretches, short stalls, and
  // now and then a long one, so back pressure hits every phase of the work.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall <= 1'b1;
          stall_hold <= $urandom_range(20, 60);
        end
        1, 2, 3, 4, 5, 6, 7: begin
          out_stall <= 1'b1;
          stall_hold <= $urandom_range(0, 3);
        end
        default: begin
          out_stall <= 1'b0;
          stall_hold <= $urandom_range(1, 25);
        end
      endcase
    end
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [sbb_pkg::CHAN_W-1:0] rand_channel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Sender gaps are mostly absent, sometimes a few cycles, rarely long.
  task automatic sender_gap();
    int n;
    case ($urandom_range(0, 19))
      0: n = $urandom_range(10, 40);
      1, 2, 3, 4, 5: n = $urandom_range(1, 3);
      default: n = 0;
    endcase
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(logic op);
    sbb_pkg::in_item_t it;
    it.opcode = op;
    it.red_in = rand_channel();
    it.green_in = rand_channel();
    it.blue_in = rand_channel();
    sender_gap();
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Registers are only touched with nothing in flight; the settle time covers
  // work still going on for items that yield no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbb_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sbb_pkg::REG_IMAGE_WIDTH:  cur_width = val[sbb_pkg::WIDTH_W-1:0];
      sbb_pkg::REG_IMAGE_HEIGHT: cur_height = val[sbb_pkg::HEIGHT_W-1:0];
      sbb_pkg::REG_BLUR_RADIUS:  cur_radius = val[sbb_pkg::RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned r);
    wait_idle();
    write_reg(sbb_pkg::REG_IMAGE_WIDTH, sbb_pkg::CFG_DATA_W'(w));
    write_reg(sbb_pkg::REG_IMAGE_HEIGHT, sbb_pkg::CFG_DATA_W'(h));
    write_reg(sbb_pkg::REG_BLUR_RADIUS, sbb_pkg::CFG_DATA_W'(r));
  endtask

  // Sends a frame of num_px pixels. A full frame is followed by its drain
  // tail, where some items are pixels that the block must treat as drains.
  // Stray drains inside the frame are ignored by the block and not counted.
  task automatic run_frame(int unsigned num_px, bit full);
    int unsigned w, h, r, tail;
    w = clip(cur_width, 1, 2048);
    h = clip(cur_height, 1, 4096);
    r = clip(cur_radius, 0, 15);
    for (int unsigned i = 0; i < num_px; i++) begin
      if ($urandom_range(0, 29) == 0) send_item(sbb_pkg::OP_DRAIN);
      send_item(sbb_pkg::OP_PIXEL);
      items_sent++;
    end
    if (full) begin
      tail = (r * w + r < w * h) ? r * w + r : w * h;
      for (int unsigned i = 0; i < tail; i++) begin
        send_item(($urandom_range(0, 9) == 0) ? sbb_pkg::OP_PIXEL : sbb_pkg::OP_DRAIN);
        items_sent++;
      end
    end
  endtask

  initial begin
    int unsigned w, h, r, np;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = sbb_pkg::REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    items_sent = 0;
    cur_width = sbb_pkg::WIDTH_RESET;
    cur_height = sbb_pkg::HEIGHT_RESET;
    cur_radius = sbb_pkg::RADIUS_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Small frame with default radius; a drain before any pixel is ignored.
    configure(4, 3, 1);
    send_item(sbb_pkg::OP_DRAIN);
    run_frame(12, 1'b1);
    // The unused register index must leave the frame alone.
    wait_idle();
    write_reg(REG_NONE, 13'h1fff);
    configure(3, 2, 0);
    run_frame(6, 1'b1);
    // Zero sizes act as one; radius far larger than the frame.
    configure(0, 0, 9);
    run_frame(1, 1'b1);
    configure(5, 4, 2);
    run_frame(7, 1'b0);
    // Abandon that partial frame by rewriting the registers.
    configure(5, 4, 2);
    run_frame(20, 1'b1);
    // Oversized width clipped to the widest row; the start of that frame.
    configure(13'h1fff, 2, 0);
    run_frame(300, 1'b0);
    // Single column at the largest radius with the height above its ceiling;
    // the first rows are enough to wrap the row ring several times.
    configure(1, 13'h1fff, 15);
    run_frame(300, 1'b0);

    while (items_sent < TOTAL_ITEMS) begin
      wait_idle();
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
      h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
      r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      if ($urandom_range(0, 1)) w = w | (13'($urandom_range(0, 1)) << sbb_pkg::WIDTH_W);
      write_reg(sbb_pkg::REG_IMAGE_WIDTH, sbb_pkg::CFG_DATA_W'(w));
      write_reg(sbb_pkg::REG_IMAGE_HEIGHT, sbb_pkg::CFG_DATA_W'(h));
      if ($urandom_range(0, 3) != 0) begin
        write_reg(sbb_pkg::REG_BLUR_RADIUS, sbb_pkg::CFG_DATA_W'(r));
      end
      repeat ($urandom_range(1, 3)) begin
        np = clip(cur_width, 1, 2048) * clip(cur_height, 1, 4096);
        if ($urandom_range(0, 7) == 0) begin
          run_frame($urandom_range(0, np - 1), 1'b0);
          break;
        end
        run_frame(np, 1'b1);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS separable_box_blur_rgb_unit");
    end else begin
      $display("FAIL separable_box_blur_rgb_unit");
    end
    $finish;
  end

endmodule
